@@ hw/rtl/sma_pkg.sv @@
// shared types and constants of the spectrum magnitude averager
package sma_pkg;

	localparam int BIN_W     = 16;
	localparam int ROOT_W    = 16;
	localparam int RAD_W     = 2 * ROOT_W;
	localparam int SUM_W     = 24;
	localparam int MEAN_W    = 16;
	localparam int COL_W     = 8;
	localparam int CNT_W     = 9;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT = 1'd1;

	localparam logic [CNT_W-1:0]  CNT_RESET = 9'd1;
	localparam logic [MEAN_W-1:0] MEAN_MAX  = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_RT_GO,
		ST_RT_WAIT,
		ST_ACC,
		ST_DIV_WAIT
	} sma_state_t;

endpackage

@@ hw/rtl/sma_if.sv @@
// valid/ready channels for input bins and averaged results
interface sma_bin_if;
	logic                              valid;
	logic                              ready;
	logic signed [sma_pkg::BIN_W-1:0] bin_real;
	logic signed [sma_pkg::BIN_W-1:0] bin_imag;

	modport source (output valid, bin_real, bin_imag, input ready);
	modport sink (input valid, bin_real, bin_imag, output ready);
endinterface

interface sma_res_if;
	logic                        valid;
	logic                        ready;
	logic [sma_pkg::MEAN_W-1:0] mean_magnitude;
	logic [sma_pkg::COL_W-1:0]  column_index;
	logic                        row_end;

	modport source (output valid, mean_magnitude, column_index, row_end, input ready);
	modport sink (input valid, mean_magnitude, column_index, row_end, output ready);
endinterface

@@ hw/rtl/sma_ram.sv @@
// generic single-port-write ram with registered read
module sma_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/sma_sqrt.sv @@
// digit-serial integer square root, two radicand bits per cycle
module sma_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sma_pkg::RAD_W-1:0]  radicand,
	output logic                       busy,
	output logic [sma_pkg::ROOT_W-1:0] root
);

	localparam int REM_W = sma_pkg::ROOT_W + 2;
	localparam int EXT_W = REM_W + 2;
	localparam int CW    = $clog2(sma_pkg::ROOT_W);

	logic [sma_pkg::RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]           rem_q;
	logic [sma_pkg::ROOT_W-1:0] root_q;
	logic [CW-1:0]              cnt_q;
	logic                       busy_q;

	logic [EXT_W-1:0] rem_ext;
	logic [EXT_W-1:0] trial;
	logic             ge;
	logic [EXT_W-1:0] rem_nxt;

	always_comb begin
		rem_ext = {rem_q, rad_q[sma_pkg::RAD_W-1 -: 2]};
		trial   = {2'b00, root_q, 2'b01};
		ge      = rem_ext >= trial;
		rem_nxt = ge ? rem_ext - trial : rem_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(sma_pkg::ROOT_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[sma_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= rem_nxt[REM_W-1:0];
			root_q <= {root_q[sma_pkg::ROOT_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

@@ hw/rtl/sma_div.sv @@
// bit-serial restoring divider for the column mean
module sma_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sma_pkg::SUM_W-1:0] dividend,
	input  logic [sma_pkg::CNT_W-1:0] divisor,
	output logic                      busy,
	output logic [sma_pkg::SUM_W-1:0] quotient
);

	localparam int CW = $clog2(sma_pkg::SUM_W);

	logic [sma_pkg::SUM_W-1:0] dvd_q;
	logic [sma_pkg::CNT_W-1:0] dvs_q;
	logic [sma_pkg::CNT_W-1:0] rem_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;

	logic [sma_pkg::CNT_W:0] r_ext;
	logic                    ge;
	logic [sma_pkg::CNT_W:0] r_nxt;

	always_comb begin
		r_ext = {rem_q, dvd_q[sma_pkg::SUM_W-1]};
		ge    = r_ext >= {1'b0, dvs_q};
		r_nxt = ge ? r_ext - {1'b0, dvs_q} : r_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(sma_pkg::SUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[sma_pkg::SUM_W-2:0], ge};
			rem_q <= r_nxt[sma_pkg::CNT_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;

endmodule

@@ hw/rtl/spectrum_magnitude_averager.sv @@
// top level: bin magnitude, per-column accumulation and group mean
// Bins arrive in row-major order, column_count per row. Each bin is squared on
// the shared multiplier, real part then imaginary part, starts and waits for the
// two-bits-per-cycle square root, does a read-modify-write of the column store
// and returns to idle to take the next bin. On the last row of a group the
// bit-serial divider also runs, and its result is loaded into the output register
// once the divider is done and that register is free. One bin is in work at a
// time; a finished result sits in an output register, so the next bin is taken
// while it waits. The column store has no clearing pass: the first row of a
// group overwrites each entry. Counts of 0 act as 1, counts above the maximum
// act as the maximum. Configuration must be written only while the block is
// idle; the block itself does not enforce it.
module spectrum_magnitude_averager #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_AVERAGE = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sma_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sma_pkg::CNT_W-1:0]     cfg_data,
	sma_bin_if.sink                       bin,
	sma_res_if.source                     res
);

	localparam int PW = $clog2(MAX_COLUMNS);
	localparam int RW = (MAX_AVERAGE > 1) ? $clog2(MAX_AVERAGE) : 1;

	sma_pkg::sma_state_t state_q, state_d;

	logic [sma_pkg::CNT_W-1:0] cc_q;
	logic [sma_pkg::CNT_W-1:0] ac_q;
	logic [PW-1:0]             pos_q;
	logic [RW-1:0]             row_q;

	logic signed [sma_pkg::BIN_W-1:0] re_q;
	logic signed [sma_pkg::BIN_W-1:0] im_q;
	logic [sma_pkg::RAD_W-1:0]        sq_q;

	logic                       out_valid_q;
	logic [sma_pkg::MEAN_W-1:0] mean_q;
	logic [sma_pkg::COL_W-1:0]  col_q;
	logic                       end_q;
	logic [sma_pkg::COL_W-1:0]  pend_col_q;
	logic                       pend_end_q;

	logic bin_ready;
	logic bin_accept;
	logic sqrt_start;
	logic acc_en;
	logic div_start;
	logic out_load;

	logic [sma_pkg::CNT_W-1:0] cols_eff;
	logic [sma_pkg::CNT_W-1:0] avg_eff;
	logic                      last_col;
	logic                      last_row;

	logic signed [sma_pkg::BIN_W-1:0]   mul_op;
	logic signed [sma_pkg::RAD_W-1:0]   mul_prod;
	logic                               sqrt_busy;
	logic [sma_pkg::ROOT_W-1:0]         mag;
	logic [sma_pkg::SUM_W-1:0]          ram_rd;
	logic [sma_pkg::SUM_W-1:0]          sum;
	logic                               div_busy;
	logic [sma_pkg::SUM_W-1:0]          quot;

	// effective counts
	always_comb begin
		if (cc_q == '0) begin
			cols_eff = sma_pkg::CNT_W'(1);
		end else if (32'(cc_q) > MAX_COLUMNS) begin
			cols_eff = sma_pkg::CNT_W'(MAX_COLUMNS);
		end else begin
			cols_eff = cc_q;
		end
		if (ac_q == '0) begin
			avg_eff = sma_pkg::CNT_W'(1);
		end else if (32'(ac_q) > MAX_AVERAGE) begin
			avg_eff = sma_pkg::CNT_W'(MAX_AVERAGE);
		end else begin
			avg_eff = ac_q;
		end
		last_col = (32'(pos_q) + 32'd1) >= 32'(cols_eff);
		last_row = (32'(row_q) + 32'd1) >= 32'(avg_eff);
	end

	assign bin_accept = bin.valid & bin_ready;
	assign bin.ready  = bin_ready;
	assign div_start  = acc_en & last_row;

	assign mul_op   = (state_q == sma_pkg::ST_SQ_RE) ? re_q : im_q;
	assign mul_prod = mul_op * mul_op;

	assign sum = (row_q == '0) ? sma_pkg::SUM_W'(mag) : ram_rd + sma_pkg::SUM_W'(mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sma_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		bin_ready  = 1'b0;
		sqrt_start = 1'b0;
		acc_en     = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			sma_pkg::ST_IDLE: begin
				bin_ready = 1'b1;
				if (bin.valid) begin
					state_d = sma_pkg::ST_SQ_RE;
				end
			end
			sma_pkg::ST_SQ_RE: begin
				state_d = sma_pkg::ST_SQ_IM;
			end
			sma_pkg::ST_SQ_IM: begin
				state_d = sma_pkg::ST_RT_GO;
			end
			sma_pkg::ST_RT_GO: begin
				sqrt_start = 1'b1;
				state_d    = sma_pkg::ST_RT_WAIT;
			end
			sma_pkg::ST_RT_WAIT: begin
				if (!sqrt_busy) begin
					state_d = sma_pkg::ST_ACC;
				end
			end
			sma_pkg::ST_ACC: begin
				acc_en  = 1'b1;
				state_d = last_row ? sma_pkg::ST_DIV_WAIT : sma_pkg::ST_IDLE;
			end
			sma_pkg::ST_DIV_WAIT: begin
				if (!div_busy && (!out_valid_q || res.ready)) begin
					out_load = 1'b1;
					state_d  = sma_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sma_pkg::ST_IDLE;
			end
		endcase
	end

	// configuration and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q  <= sma_pkg::CNT_RESET;
			ac_q  <= sma_pkg::CNT_RESET;
			pos_q <= '0;
			row_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sma_pkg::CFG_COLUMN_COUNT:  cc_q <= cfg_data;
					sma_pkg::CFG_AVERAGE_COUNT: ac_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (acc_en) begin
				if (last_col) begin
					pos_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bin_accept) begin
			re_q <= bin.bin_real;
			im_q <= bin.bin_imag;
		end
		if (state_q == sma_pkg::ST_SQ_RE) begin
			sq_q <= $unsigned(mul_prod);
		end else if (state_q == sma_pkg::ST_SQ_IM) begin
			sq_q <= sq_q + $unsigned(mul_prod);
		end
		if (acc_en) begin
			pend_col_q <= sma_pkg::COL_W'(pos_q);
			pend_end_q <= last_col;
		end
		if (out_load) begin
			mean_q <= (|quot[sma_pkg::SUM_W-1:sma_pkg::MEAN_W]) ? sma_pkg::MEAN_MAX
				: quot[sma_pkg::MEAN_W-1:0];
			col_q  <= pend_col_q;
			end_q  <= pend_end_q;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.mean_magnitude = mean_q;
	assign res.column_index   = col_q;
	assign res.row_end        = end_q;

	sma_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sq_q),
		.busy     (sqrt_busy),
		.root     (mag)
	);

	sma_ram #(
		.WIDTH (sma_pkg::SUM_W),
		.DEPTH (MAX_COLUMNS)
	) u_sums (
		.clk     (clk),
		.wr_en   (acc_en),
		.wr_addr (pos_q),
		.wr_data (sum),
		.rd_en   (bin_accept),
		.rd_addr (pos_q),
		.rd_data (ram_rd)
	);

	sma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum),
		.divisor  (avg_eff),
		.busy     (div_busy),
		.quotient (quot)
	);

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(sqrt_busy && div_busy))
		else $error("root and divider busy together");

	a_accept_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		bin_accept |-> (!sqrt_busy && !div_busy))
		else $error("bin taken while a unit is busy");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) < MAX_COLUMNS)
		else $error("column position out of range");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) < MAX_AVERAGE)
		else $error("row counter out of range");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res.ready) |=> !$past(out_load))
		else $error("output overwritten while waiting");

endmodule
